@@ sv/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Short forms for the concurrent checks used in the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst, expr, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Consequent holds in the same cycle as the antecedent
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ sv/dsc_pkg.sv @@
// ----------------------------------------------------------------------------
// dsc_pkg
// Shared constants and command type for the dice sum counter.
// ----------------------------------------------------------------------------
package dsc_pkg;

   // field widths
   localparam int TOTAL_W = 60;
   localparam int COUNT_W = 30;
   // exponent is total + 1, which needs one more bit
   localparam int EXP_W   = TOTAL_W + 1;

   // default number of die faces
   localparam int FACES_DEF = 6;

   // modulus and Barrett constant floor(2^60 / PRIME)
   localparam logic [COUNT_W-1:0] PRIME = 30'd1000000007;
   localparam logic [30:0] BARRETT_MU = 31'((64'd1 << 60) / 64'd1000000007);

   // command from controller to datapath
   typedef struct packed {
      logic init_wr;    // write identity / companion entry at row, col
      logic mac;        // multiply-accumulate step at row, col, kk
      logic mac_first;  // first term of a dot product
      logic mac_last;   // last term: write result to scratch matrix
      logic x_from_b;   // left operand from base matrix (squaring)
      logic copy;       // copy scratch entry at row, col
      logic copy_to_b;  // copy destination is base matrix
      logic load_out;   // load result register from accumulator matrix
   } cmd_type;

endpackage

@@ sv/dsc_dpath.sv @@
// ----------------------------------------------------------------------------
// dsc_dpath
// Matrix stores and modular multiply-accumulate pipeline.
// ----------------------------------------------------------------------------
module dsc_dpath #(
   parameter  int FACES = dsc_pkg::FACES_DEF,
   localparam int IDX_W = (FACES > 1) ? $clog2(FACES) : 1
) (
   input  logic                         clock,
   input  logic                         reset,
   input  dsc_pkg::cmd_type             cmd,
   input  logic [IDX_W-1:0]             row,
   input  logic [IDX_W-1:0]             col,
   input  logic [IDX_W-1:0]             kk,
   output logic                         dp_busy,
   output logic [dsc_pkg::COUNT_W-1:0]  way_count
);

   localparam int AW    = 2 * IDX_W;
   localparam int DEPTH = 1 << AW;
   localparam int CW    = dsc_pkg::COUNT_W;

   // matrix stores: accumulator, base and scratch
   logic [CW-1:0] acc_mem  [DEPTH];
   logic [CW-1:0] base_mem [DEPTH];
   logic [CW-1:0] tmp_mem  [DEPTH];

   logic [CW-1:0] a_rd_ff, b0_rd_ff, b1_rd_ff, t_rd_ff;

   // pipeline tags, stage 1 to 5
   logic [5:1]    mac_v_ff, first_ff, last_ff;
   logic          x_b_ff;
   logic [AW-1:0] dst_ff [1:5];

   logic          copy_v_ff, copy_b_ff;
   logic [AW-1:0] copy_addr_ff;

   // arithmetic stage registers
   logic [59:0]   prod_ff, prod_in;
   logic [59:0]   prod3_ff;
   logic [61:0]   bq_ff, bq_in;
   logic [31:0]   qp_ff, x4_ff;
   logic [60:0]   qp_full;
   logic [CW-1:0] red_ff, red_in;
   logic [CW-1:0] acc_ff, acc_sum;
   logic [CW-1:0] way_ff;

   logic [CW-1:0] a_init, b_init, x_op;
   logic [31:0]   diff;
   logic [32:0]   diff1, diff2;
   logic [CW:0]   sum;
   logic [CW+1:0] sum1;
   logic [AW-1:0] here_addr;

   assign here_addr = {row, col};

   // initial matrices: identity and companion
   always_comb begin
      a_init = (row == col) ? CW'(1) : '0;
      b_init = ((row == '0) || ({1'b0, row} == ({1'b0, col} + (IDX_W+1)'(1)))) ?
               CW'(1) : '0;
   end

   // accumulator store: one write port, one read port
   always_ff @(posedge clock) begin
      if (cmd.init_wr) begin
         acc_mem[here_addr] <= a_init;
      end else if (copy_v_ff && !copy_b_ff) begin
         acc_mem[copy_addr_ff] <= t_rd_ff;
      end
      a_rd_ff <= acc_mem[{row, kk}];
   end

   // base store: one write port, two read ports
   always_ff @(posedge clock) begin
      if (cmd.init_wr) begin
         base_mem[here_addr] <= b_init;
      end else if (copy_v_ff && copy_b_ff) begin
         base_mem[copy_addr_ff] <= t_rd_ff;
      end
      b0_rd_ff <= base_mem[{row, kk}];
      b1_rd_ff <= base_mem[{kk, col}];
   end

   // scratch store: written by the accumulate stage, read for copies
   always_ff @(posedge clock) begin
      if (mac_v_ff[5] && last_ff[5]) begin
         tmp_mem[dst_ff[5]] <= acc_sum;
      end
      t_rd_ff <= tmp_mem[here_addr];
   end

   // control tags
   always_ff @(posedge clock) begin
      if (reset) begin
         mac_v_ff  <= '0;
         copy_v_ff <= 1'b0;
      end else begin
         mac_v_ff  <= {mac_v_ff[4:1], cmd.mac};
         copy_v_ff <= cmd.copy;
      end
   end

   // tag payload travels with the data
   always_ff @(posedge clock) begin
      first_ff     <= {first_ff[4:1], cmd.mac_first};
      last_ff      <= {last_ff[4:1], cmd.mac_last};
      x_b_ff       <= cmd.x_from_b;
      dst_ff[1]    <= here_addr;
      for (int i = 2; i <= 5; i++) begin
         dst_ff[i] <= dst_ff[i-1];
      end
      copy_b_ff    <= cmd.copy_to_b;
      copy_addr_ff <= here_addr;
   end

   // stage 2 product, stage 3 Barrett quotient estimate, stage 4 q * p
   always_comb begin
      x_op    = x_b_ff ? b0_rd_ff : a_rd_ff;
      prod_in = 60'(x_op) * 60'(b1_rd_ff);
      bq_in   = 62'(prod_ff[59:29]) * 62'(dsc_pkg::BARRETT_MU);
      qp_full = 61'(bq_ff[61:31]) * 61'(dsc_pkg::PRIME);
   end

   // stage 5: remainder is below three times the modulus, fix it up
   always_comb begin
      diff   = x4_ff - qp_ff;
      diff1  = {1'b0, diff} - 33'(dsc_pkg::PRIME);
      diff2  = {1'b0, diff} - (33'(dsc_pkg::PRIME) << 1);
      if (!diff2[32]) begin
         red_in = diff2[CW-1:0];
      end else if (!diff1[32]) begin
         red_in = diff1[CW-1:0];
      end else begin
         red_in = diff[CW-1:0];
      end
   end

   // accumulate with one conditional subtract
   always_comb begin
      sum     = {1'b0, (first_ff[5] ? '0 : acc_ff)} + {1'b0, red_ff};
      sum1    = {1'b0, sum} - (CW+2)'(dsc_pkg::PRIME);
      acc_sum = sum1[CW+1] ? sum[CW-1:0] : sum1[CW-1:0];
   end

   always_ff @(posedge clock) begin
      prod_ff  <= prod_in;
      bq_ff    <= bq_in;
      prod3_ff <= prod_ff;
      qp_ff    <= qp_full[31:0];
      x4_ff    <= prod3_ff[31:0];
      red_ff   <= red_in;
      if (mac_v_ff[5]) begin
         acc_ff <= acc_sum;
      end
      if (cmd.load_out) begin
         way_ff <= a_rd_ff;
      end
   end

   assign dp_busy   = (|mac_v_ff) || copy_v_ff;
   assign way_count = way_ff;

endmodule

@@ sv/dsc_ctrl.sv @@
// ----------------------------------------------------------------------------
// dsc_ctrl
// Sequencer for square-and-multiply over the matrix datapath.
// ----------------------------------------------------------------------------
module dsc_ctrl #(
   parameter  int FACES = dsc_pkg::FACES_DEF,
   localparam int IDX_W = (FACES > 1) ? $clog2(FACES) : 1
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [dsc_pkg::TOTAL_W-1:0]  req_target_total,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output dsc_pkg::cmd_type             cmd,
   output logic [IDX_W-1:0]             row,
   output logic [IDX_W-1:0]             col,
   output logic [IDX_W-1:0]             kk,
   input  logic                         dp_busy
);

   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(FACES - 1);
   localparam int EW = dsc_pkg::EXP_W;

   typedef enum logic [9:0] {
      ST_IDLE   = 10'b00_0000_0001,
      ST_INIT   = 10'b00_0000_0010,
      ST_STEP   = 10'b00_0000_0100,
      ST_SHIFT  = 10'b00_0000_1000,
      ST_MUL    = 10'b00_0001_0000,
      ST_DRAIN  = 10'b00_0010_0000,
      ST_COPY   = 10'b00_0100_0000,
      ST_CDRAIN = 10'b00_1000_0000,
      ST_OUT_RD = 10'b01_0000_0000,
      ST_OUT_LD = 10'b10_0000_0000
   } state_type;

   state_type        state_ff, state_in;
   logic [IDX_W-1:0] r_ff, r_in, c_ff, c_in, k_ff, k_in;
   logic [EW-1:0]    expo_ff, expo_in;
   logic             mode_ff, mode_in;   // low: acc * base, high: base * base
   logic             rsp_valid_ff, rsp_valid_in;
   logic             out_sel;
   logic             r_last, c_last, k_last;

   assign r_last = (r_ff == IDX_LAST);
   assign c_last = (c_ff == IDX_LAST);
   assign k_last = (k_ff == IDX_LAST);

   always_comb begin
      state_in     = state_ff;
      r_in         = r_ff;
      c_in         = c_ff;
      k_in         = k_ff;
      expo_in      = expo_ff;
      mode_in      = mode_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      req_ready    = 1'b0;
      out_sel      = 1'b0;
      cmd          = '0;

      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               expo_in  = {1'b0, req_target_total} + EW'(1);
               state_in = ST_INIT;
            end
         end
         // build identity and companion matrices, one entry a cycle
         ST_INIT: begin
            cmd.init_wr = 1'b1;
            if (c_last) begin
               c_in = '0;
               if (r_last) begin
                  r_in     = '0;
                  state_in = ST_STEP;
               end else begin
                  r_in = r_ff + IDX_W'(1);
               end
            end else begin
               c_in = c_ff + IDX_W'(1);
            end
         end
         ST_STEP: begin
            if (expo_ff[0]) begin
               mode_in  = 1'b0;
               state_in = ST_MUL;
            end else begin
               state_in = ST_SHIFT;
            end
         end
         ST_SHIFT: begin
            expo_in = expo_ff >> 1;
            if ((expo_ff >> 1) != '0) begin
               mode_in  = 1'b1;
               state_in = ST_MUL;
            end else begin
               state_in = ST_OUT_RD;
            end
         end
         // one multiply-accumulate per cycle, k innermost
         ST_MUL: begin
            cmd.mac       = 1'b1;
            cmd.mac_first = (k_ff == '0);
            cmd.mac_last  = k_last;
            cmd.x_from_b  = mode_ff;
            if (k_last) begin
               k_in = '0;
               if (c_last) begin
                  c_in = '0;
                  if (r_last) begin
                     r_in     = '0;
                     state_in = ST_DRAIN;
                  end else begin
                     r_in = r_ff + IDX_W'(1);
                  end
               end else begin
                  c_in = c_ff + IDX_W'(1);
               end
            end else begin
               k_in = k_ff + IDX_W'(1);
            end
         end
         ST_DRAIN: begin
            if (!dp_busy) begin
               state_in = ST_COPY;
            end
         end
         // move the product into its destination matrix
         ST_COPY: begin
            cmd.copy      = 1'b1;
            cmd.copy_to_b = mode_ff;
            if (c_last) begin
               c_in = '0;
               if (r_last) begin
                  r_in     = '0;
                  state_in = ST_CDRAIN;
               end else begin
                  r_in = r_ff + IDX_W'(1);
               end
            end else begin
               c_in = c_ff + IDX_W'(1);
            end
         end
         ST_CDRAIN: begin
            if (!dp_busy) begin
               state_in = mode_ff ? ST_STEP : ST_SHIFT;
            end
         end
         ST_OUT_RD: begin
            out_sel  = 1'b1;
            state_in = ST_OUT_LD;
         end
         // wait for the output register to be free
         ST_OUT_LD: begin
            out_sel = 1'b1;
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_out = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         r_ff         <= '0;
         c_ff         <= '0;
         k_ff         <= '0;
         mode_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         r_ff         <= r_in;
         c_ff         <= c_in;
         k_ff         <= k_in;
         mode_ff      <= mode_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      expo_ff <= expo_in;
   end

   assign row       = r_ff;
   assign col       = c_ff;
   assign kk        = out_sel ? IDX_LAST : k_ff;
   assign rsp_valid = rsp_valid_ff;

endmodule

@@ sv/dice_sum_count_matrix_power.sv @@
// ----------------------------------------------------------------------------
// dice_sum_count_matrix_power
// Counts ordered die-throw sequences reaching a total, modulo 1000000007,
// by raising the companion matrix to the power total + 1.
// ----------------------------------------------------------------------------
//
//   channel   direction  handshake              payload
//   req       in         req_valid / req_ready  req_target_total [59:0]
//   rsp       out        rsp_valid / rsp_ready  rsp_way_count [29:0]
//
// Items are taken one at a time. An item needs P = L - 1 + (one bits of total + 1) matrix
// products, with L the bit length of total + 1; one shared multiply-reduce pipeline does them,
// a multiply-accumulate per cycle while a product is issued, draining between products.
// Reset clears the controller and the datapath valid tags; the matrices are rebuilt for every item.
// A new transfer is taken while a result waits in the output register; a
// finished result waits for that register to be free.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dice_sum_count_matrix_power #(
   parameter int FACES = dsc_pkg::FACES_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [dsc_pkg::TOTAL_W-1:0]  req_target_total,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [dsc_pkg::COUNT_W-1:0]  rsp_way_count
);

   localparam int IDX_W = (FACES > 1) ? $clog2(FACES) : 1;

   dsc_pkg::cmd_type  cmd;
   logic [IDX_W-1:0]  row, col, kk;
   logic              dp_busy;

   dsc_ctrl #(
      .FACES (FACES)
   ) u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_target_total (req_target_total),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .cmd              (cmd),
      .row              (row),
      .col              (col),
      .kk               (kk),
      .dp_busy          (dp_busy)
   );

   dsc_dpath #(
      .FACES (FACES)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .row       (row),
      .col       (col),
      .kk        (kk),
      .dp_busy   (dp_busy),
      .way_count (rsp_way_count)
   );

   // checks
   `ASSERT_ALWAYS(a_cmd_excl, clock, reset, $onehot0({cmd.init_wr, cmd.mac, cmd.copy, cmd.load_out}), "more than one datapath command at once")
   `ASSERT_IMPLIES(a_load_free, clock, reset, cmd.load_out, (!rsp_valid || rsp_ready), "result loaded over an untaken result")
   `ASSERT_IMPLIES(a_copy_drained, clock, reset, (cmd.copy && !$past(cmd.copy)), !dp_busy, "copy started before the pipeline drained")
   `ASSERT_NEXT(a_one_item, clock, reset, (req_valid && req_ready), !req_ready, "second transfer taken while an item is in work")

endmodule
